>>> sv/tsil_pkg.sv
// ----------------------------------------------------------------------------
// tsil_pkg
// Shared types and constants of the tire sensor ID learner.
// ----------------------------------------------------------------------------
package tsil_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int RAW_HIGH_W = 64;
    localparam int RAW_LOW_W  = 16;
    localparam int TIME_W     = 32;
    localparam int PREFIX_W   = 8;
    localparam int ADDR_W     = 24;
    localparam int PRESS_W    = 10;
    localparam int RANK_W     = 4;
    localparam int COUNT_W    = 16;
    localparam int USED_W     = 5;

    localparam int PACKET_W   = RAW_HIGH_W + RAW_LOW_W;
    localparam int PAIRS      = 37;
    localparam int ACC_W      = PAIRS + 7;
    localparam int PREFIX_LSB = 34;
    localparam int ADDR_LSB   = 10;

    localparam logic [7:0]         INVALID_PAIR_BITS = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 16'hFFFF;

    typedef enum logic [1:0] {
        ACT_UNCONF = 2'd0,
        ACT_RAISE  = 2'd1,
        ACT_ADD    = 2'd2,
        ACT_FULL   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_BUB_RD,
        S_BUB_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  first_seen;
    } t_entry;

    typedef struct packed {
        logic    accept;
        logic    clr_idx;
        logic    inc_idx;
        logic    dec_idx;
        logic    rd_idx;
        logic    rd_prev;
        logic    take_hit;
        logic    wr_shift;
        logic    wr_ent;
        logic    wr_new;
        logic    res_set;
        t_action act;
    } t_cmd;

    typedef struct packed {
        logic pkt_valid;
        logic confirm;
        logic idx_lt_used;
        logic full;
        logic hit;
        logic idx_zero;
        logic prev_lower;
        logic res_busy;
    } t_sts;

endpackage

>>> sv/tsil_if.sv
// ----------------------------------------------------------------------------
// tsil_if
// Valid/ready channels for raw packets and learner results.
// ----------------------------------------------------------------------------
interface tsil_in_if;
    import tsil_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [RAW_HIGH_W-1:0] raw_high;
    logic [RAW_LOW_W-1:0]  raw_low;
    logic [TIME_W-1:0]     time_ms;

    modport source (output valid, output raw_high, output raw_low, output time_ms,
                    input ready);
    modport sink   (input valid, input raw_high, input raw_low, input time_ms,
                    output ready);
endinterface

interface tsil_out_if;
    import tsil_pkg::*;

    logic                valid;
    logic                ready;
    logic [PREFIX_W-1:0] prefix;
    logic [ADDR_W-1:0]   sensor_address;
    logic [PRESS_W-1:0]  pressure;
    logic                manchester_error;
    t_action             action;
    logic [RANK_W-1:0]   entry_rank;
    logic [COUNT_W-1:0]  entry_count;
    logic [USED_W-1:0]   entries_used;

    modport source (output valid, output prefix, output sensor_address, output pressure,
                    output manchester_error, output action, output entry_rank,
                    output entry_count, output entries_used, input ready);
    modport sink   (input valid, input prefix, input sensor_address, input pressure,
                    input manchester_error, input action, input entry_rank,
                    input entry_count, input entries_used, output ready);
endinterface

>>> sv/tsil_ram.sv
// ----------------------------------------------------------------------------
// tsil_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tsil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/tsil_ctrl.sv
// ----------------------------------------------------------------------------
// tsil_ctrl
// Sequencer for decode, table search, reorder walk and result hand-off.
// ----------------------------------------------------------------------------
module tsil_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tsil_pkg::t_sts i_sts,
    output tsil_pkg::t_cmd o_cmd
);
    import tsil_pkg::*;

    t_state  r_state, n_state;
    t_action r_act, n_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= ACT_UNCONF;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
        end
    end

    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.pkt_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.confirm) begin
                    n_state = S_SRCH_RD;
                end else begin
                    n_act   = ACT_UNCONF;
                    n_state = S_DONE;
                end
            end
            S_SRCH_RD: begin
                if (i_sts.idx_lt_used) begin
                    n_state = S_SRCH_CMP;
                end else begin
                    n_act   = i_sts.full ? ACT_FULL : ACT_ADD;
                    n_state = S_DONE;
                end
            end
            S_SRCH_CMP: begin
                n_state = i_sts.hit ? S_BUB_RD : S_SRCH_RD;
            end
            S_BUB_RD: begin
                if (i_sts.idx_zero) begin
                    n_act   = ACT_RAISE;
                    n_state = S_DONE;
                end else begin
                    n_state = S_BUB_CMP;
                end
            end
            S_BUB_CMP: begin
                if (i_sts.prev_lower) begin
                    n_state = S_BUB_RD;
                end else begin
                    n_act   = ACT_RAISE;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.res_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_cmd.act = r_act;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = 1'b1;
            end
            S_DECIDE: begin
                o_cmd.clr_idx = 1'b1;
            end
            S_SRCH_RD: begin
                if (i_sts.idx_lt_used) begin
                    o_cmd.rd_idx = 1'b1;
                end else if (!i_sts.full) begin
                    o_cmd.wr_new = 1'b1;
                end
            end
            S_SRCH_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.take_hit = 1'b1;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_BUB_RD: begin
                if (i_sts.idx_zero) begin
                    o_cmd.wr_ent = 1'b1;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                end
            end
            S_BUB_CMP: begin
                if (i_sts.prev_lower) begin
                    o_cmd.wr_shift = 1'b1;
                    o_cmd.dec_idx  = 1'b1;
                end else begin
                    o_cmd.wr_ent = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.res_set = !i_sts.res_busy;
            end
            default: o_cmd = '0;
        endcase
    end
endmodule

>>> sv/tsil_dpath.sv
// ----------------------------------------------------------------------------
// tsil_dpath
// Manchester decoder, sensor table storage and result register.
// ----------------------------------------------------------------------------
module tsil_dpath #(
    parameter int TABLE_ENTRIES = tsil_pkg::TABLE_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tsil_in_if.sink        i_pkt,
    tsil_out_if.source     o_res,
    input  tsil_pkg::t_cmd i_cmd,
    output tsil_pkg::t_sts o_sts
);
    import tsil_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    function automatic logic [ACC_W:0] decode_packet(input logic [PACKET_W-1:0] pkt);
        logic [ACC_W-1:0] acc;
        logic             err;
        logic             a;
        logic             b;
        acc = '0;
        err = 1'b0;
        for (int k = 0; k < PAIRS; k++) begin
            a = pkt[PACKET_W - 2 - 2 * k];
            b = pkt[PACKET_W - 3 - 2 * k];
            if (a && !b) begin
                acc = acc | (ACC_W'(1) << (PAIRS - 1 - k));
            end else if (a == b) begin
                acc = acc | (ACC_W'(INVALID_PAIR_BITS) << (PAIRS - 1 - k));
                err = 1'b1;
            end
        end
        return {err, acc};
    endfunction

    logic [ACC_W:0]     w_dec;
    logic [ADDR_W-1:0]  w_dec_addr;
    logic               w_load;
    t_entry             w_rdata;
    t_entry             w_wdata;
    logic               w_we;
    logic               w_re;
    logic [CNT_W-1:0]   w_idx_m1;
    logic [IDX_W-1:0]   w_raddr;
    logic [COUNT_W-1:0] w_cnt_inc;

    logic [PREFIX_W-1:0] r_prefix;
    logic [ADDR_W-1:0]   r_addr;
    logic [PRESS_W-1:0]  r_press;
    logic                r_err;
    logic [TIME_W-1:0]   r_time;
    logic                r_confirm;
    logic [ADDR_W-1:0]   r_prev;
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    r_idx;
    t_entry              r_ent;

    logic                r_res_valid;
    logic [PREFIX_W-1:0] r_res_prefix;
    logic [ADDR_W-1:0]   r_res_addr;
    logic [PRESS_W-1:0]  r_res_press;
    logic                r_res_err;
    t_action             r_res_act;
    logic [RANK_W-1:0]   r_res_rank;
    logic [COUNT_W-1:0]  r_res_count;
    logic [USED_W-1:0]   r_res_used;

    assign w_dec      = decode_packet({i_pkt.raw_high, i_pkt.raw_low});
    assign w_dec_addr = w_dec[ADDR_LSB +: ADDR_W];
    assign w_load     = i_cmd.accept && i_pkt.valid;
    assign i_pkt.ready = i_cmd.accept;

    assign w_idx_m1  = r_idx - CNT_W'(1);
    assign w_raddr   = i_cmd.rd_prev ? w_idx_m1[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign w_re      = i_cmd.rd_idx || i_cmd.rd_prev;
    assign w_we      = i_cmd.wr_shift || i_cmd.wr_ent || i_cmd.wr_new;
    assign w_cnt_inc = (w_rdata.count == COUNT_MAX) ? COUNT_MAX
                                                    : w_rdata.count + COUNT_W'(1);

    always_comb begin
        priority if (i_cmd.wr_shift) begin
            w_wdata = w_rdata;
        end else if (i_cmd.wr_ent) begin
            w_wdata = r_ent;
        end else begin
            w_wdata.addr       = r_addr;
            w_wdata.count      = COUNT_W'(1);
            w_wdata.first_seen = r_time;
        end
    end

    tsil_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_used      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_prev <= w_dec_addr;
            end
            if (i_cmd.wr_new) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (i_cmd.res_set) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_prefix  <= w_dec[PREFIX_LSB +: PREFIX_W];
            r_addr    <= w_dec_addr;
            r_press   <= w_dec[PRESS_W-1:0];
            r_err     <= w_dec[ACC_W];
            r_time    <= i_pkt.time_ms;
            r_confirm <= (w_dec_addr == r_prev);
        end
        priority if (i_cmd.clr_idx) begin
            r_idx <= '0;
        end else if (i_cmd.inc_idx) begin
            r_idx <= r_idx + CNT_W'(1);
        end else if (i_cmd.dec_idx) begin
            r_idx <= w_idx_m1;
        end
        if (i_cmd.take_hit) begin
            r_ent.addr       <= w_rdata.addr;
            r_ent.count      <= w_cnt_inc;
            r_ent.first_seen <= w_rdata.first_seen;
        end else if (i_cmd.wr_new) begin
            r_ent.count <= COUNT_W'(1);
        end
        if (i_cmd.res_set) begin
            r_res_prefix <= r_prefix;
            r_res_addr   <= r_addr;
            r_res_press  <= r_press;
            r_res_err    <= r_err;
            r_res_act    <= i_cmd.act;
            r_res_used   <= USED_W'(r_used);
            if (i_cmd.act == ACT_RAISE || i_cmd.act == ACT_ADD) begin
                r_res_rank  <= RANK_W'(r_idx);
                r_res_count <= r_ent.count;
            end else begin
                r_res_rank  <= '0;
                r_res_count <= '0;
            end
        end
    end

    assign o_sts.pkt_valid   = i_pkt.valid;
    assign o_sts.confirm     = r_confirm;
    assign o_sts.idx_lt_used = (r_idx < r_used);
    assign o_sts.full        = (r_used == FULL_CNT);
    assign o_sts.hit         = (w_rdata.addr == r_addr);
    assign o_sts.idx_zero    = (r_idx == '0);
    assign o_sts.prev_lower  = (w_rdata.count < r_ent.count);
    assign o_sts.res_busy    = r_res_valid && !o_res.ready;

    assign o_res.valid            = r_res_valid;
    assign o_res.prefix           = r_res_prefix;
    assign o_res.sensor_address   = r_res_addr;
    assign o_res.pressure         = r_res_press;
    assign o_res.manchester_error = r_res_err;
    assign o_res.action           = r_res_act;
    assign o_res.entry_rank       = r_res_rank;
    assign o_res.entry_count      = r_res_count;
    assign o_res.entries_used     = r_res_used;
endmodule

>>> sv/tpms_sensor_id_learner_top.sv
// ----------------------------------------------------------------------------
// tpms_sensor_id_learner_top
// Flow: an unconfirmed address goes straight to the result; a confirmed one searches
//   the table entry by entry, then adds a new entry or drops it when full, or moves
//   a hit entry up place by place past entries with lower counts, then loads the result.
// Throughput: one packet at a time; the next is taken the cycle after its result
//   is loaded, and a new packet is taken while a result waits.
// Reset: synchronous active low; clears previous address, fill count and result valid.
// ----------------------------------------------------------------------------
module tpms_sensor_id_learner_top #(
    parameter int TABLE_ENTRIES = tsil_pkg::TABLE_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsil_in_if.sink    i_pkt,
    tsil_out_if.source o_res
);
    import tsil_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    tsil_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    tsil_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (i_pkt),
        .o_res   (o_res),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );
endmodule

>>> sv/tsil_chk.sv
// ----------------------------------------------------------------------------
// tsil_chk
// Port-level checks of the sensor ID learner, bound to the top level.
// ----------------------------------------------------------------------------
module tsil_chk #(
    parameter int TABLE_ENTRIES = tsil_pkg::TABLE_ENTRIES_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input tsil_pkg::t_action            i_action,
    input logic [tsil_pkg::RANK_W-1:0]  i_rank,
    input logic [tsil_pkg::COUNT_W-1:0] i_count,
    input logic [tsil_pkg::USED_W-1:0]  i_used
);
    import tsil_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while previous packet in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_action)
            && $stable(i_count) && $stable(i_used))
        else $error("stalled result changed");

    a_no_touch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_action == ACT_UNCONF || i_action == ACT_FULL)
            |-> i_rank == '0 && i_count == '0)
        else $error("untouched entry reports rank or count");

    a_add_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_action == ACT_ADD
            |-> i_count == COUNT_W'(1)
                && (TABLE_ENTRIES > 15 || {1'b0, i_rank} + USED_W'(1) == i_used))
        else $error("added entry not at end of table");

    a_full_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_action == ACT_FULL
            |-> TABLE_ENTRIES > 31 || i_used == USED_W'(TABLE_ENTRIES))
        else $error("drop reported with table not full");
endmodule

bind tpms_sensor_id_learner_top tsil_chk #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
) u_tsil_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pkt.valid),
    .i_in_ready  (i_pkt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_action    (o_res.action),
    .i_rank      (o_res.entry_rank),
    .i_count     (o_res.entry_count),
    .i_used      (o_res.entries_used)
);
